[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Command and result kind codes, screen geometry and the digit character map.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int MAX_DIGITS = 32;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int BASE_W = 6;
  localparam int VAL_W  = 32;

  // Digit store addressing and fill count.
  localparam int DIG_AW = $clog2(MAX_DIGITS);
  localparam int DIG_CW = $clog2(MAX_DIGITS + 1);

  // The divider retires this many quotient bits per cycle.
  localparam int BITS_PER_STEP = 4;
  localparam int DIV_STEPS     = VAL_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(DIV_STEPS);

  localparam logic [1:0] CMD_PUT_CHAR = 2'd0;
  localparam logic [1:0] CMD_PUT_NUM  = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;
  localparam logic [1:0] CMD_CURSOR   = 2'd3;

  localparam logic [1:0] KIND_CELL   = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_CURSOR = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  // Letters start at 'a' for digit ten.
  localparam logic [7:0] CHAR_ALPHA   = 8'h57;

  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

  localparam logic [7:0] COLOR_RESET = 8'h07;

  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;

  function automatic logic [7:0] digit_char(input logic [BASE_W-1:0] d);
    logic [7:0] d8;
    d8 = {2'b00, d};
    if (d < 6'd10) begin
      digit_char = CHAR_ZERO + d8;
    end else begin
      digit_char = CHAR_ALPHA + d8;
    end
  endfunction

endpackage

[rtl/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console command engine
// Turns put-character, put-number, clear and cursor commands into cell
// writes, screen clears and cursor reports, tracking the cursor position.
// ----------------------------------------------------------------------------
// One command is taken at a time; in_stall stays high until the command is
// done and its last result, if it makes any, is in the output register. A
// number is split into digits by the shared radix divider, which retires four
// quotient bits a cycle; the digits are stored, then each is read back and
// placed (after a screen clear when the cursor has run off the bottom), and a
// cursor report ends the number. out_stall can hold any result back.
module text_console_writer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [7:0]                 cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_cmd,
  input  logic [7:0]                 in_ch,
  input  logic [tcw_pkg::VAL_W-1:0]  in_value,
  input  logic [tcw_pkg::BASE_W-1:0] in_base,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_kind,
  output tcw_pkg::col_t              out_col,
  output tcw_pkg::row_t              out_row,
  output logic [7:0]                 out_glyph,
  output logic [7:0]                 out_attr,
  output logic                       out_last
);
  import tcw_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_LOAD   = 3'd3;
  localparam logic [2:0] S_PLACE  = 3'd4;
  localparam logic [2:0] S_CURSOR = 3'd5;
  localparam logic [2:0] S_CLEAR  = 3'd6;

  localparam col_t              COL_LIM  = COL_W'(COLUMNS);
  localparam row_t              ROW_LIM  = ROW_W'(ROWS);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);
  localparam logic [DIG_CW-1:0] DIG_LIM  = DIG_CW'(MAX_DIGITS);

  logic [2:0]              state_r, state_nxt;
  logic [7:0]              color_r, color_nxt;
  col_t                    col_r, col_nxt;
  row_t                    row_r, row_nxt;
  logic [7:0]              char_r, char_nxt;
  logic                    single_r, single_nxt;
  logic [BASE_W-1:0]       base_r, base_nxt;
  logic [VAL_W-1:0]        quo_r, quo_nxt;
  logic [BASE_W-1:0]       rem_r, rem_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [DIG_CW-1:0]       cnt_r, cnt_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              out_kind_r, out_kind_nxt;
  col_t                    out_col_r, out_col_nxt;
  row_t                    out_row_r, out_row_nxt;
  logic [7:0]              out_glyph_r, out_glyph_nxt;
  logic [7:0]              out_attr_r, out_attr_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [BASE_W-1:0]       dig_mem [MAX_DIGITS];
  logic [BASE_W-1:0]       rd_r;
  logic                    dig_we;
  logic [DIG_CW-1:0]       cnt_dec;
  logic [DIG_CW-1:0]       cnt_inc;

  logic                    free;
  logic                    emit;
  logic                    accept;
  col_t                    wrap_col;
  row_t                    wrap_row;
  logic [2:0]              done_state;

  // Divider datapath, four restoring steps per cycle.
  logic [VAL_W-1:0]        dq;
  logic [BASE_W-1:0]       dr;
  logic [BASE_W:0]         trial;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign free      = !out_valid_r || !out_stall;
  assign cnt_dec   = cnt_r - 1'b1;
  assign cnt_inc   = cnt_r + 1'b1;

  always_comb begin
    dq = quo_r;
    dr = rem_r;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      trial = {dr, dq[VAL_W-1]};
      if (trial >= {1'b0, base_r}) begin
        trial = trial - {1'b0, base_r};
        dq    = {dq[VAL_W-2:0], 1'b1};
      end else begin
        dq    = {dq[VAL_W-2:0], 1'b0};
      end
      dr = trial[BASE_W-1:0];
    end
  end

  // Cursor after the wrap that precedes every placed character.
  always_comb begin
    if (col_r >= COL_LIM) begin
      wrap_col = '0;
      wrap_row = (row_r < ROW_LIM) ? row_r + 1'b1 : row_r;
    end else begin
      wrap_col = col_r;
      wrap_row = row_r;
    end
  end

  always_comb begin
    if (single_r) begin
      done_state = S_IDLE;
    end else if (cnt_r != '0) begin
      done_state = S_READ;
    end else begin
      done_state = S_CURSOR;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    color_nxt     = cfg_we ? cfg_data : color_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    char_nxt      = char_r;
    single_nxt    = single_r;
    base_nxt      = base_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    dig_we        = 1'b0;
    emit          = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_glyph_nxt = out_glyph_r;
    out_attr_nxt  = out_attr_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_PUT_CHAR: begin
              char_nxt   = in_ch;
              single_nxt = 1'b1;
              state_nxt  = S_PLACE;
            end
            CMD_PUT_NUM: begin
              if (in_value == '0) begin
                char_nxt   = CHAR_ZERO;
                single_nxt = 1'b1;
                state_nxt  = S_PLACE;
              end else if (in_base >= BASE_MIN && in_base <= BASE_MAX) begin
                base_nxt   = in_base;
                quo_nxt    = in_value;
                rem_nxt    = '0;
                step_nxt   = '0;
                cnt_nxt    = '0;
                single_nxt = 1'b0;
                state_nxt  = S_DIV;
              end
            end
            CMD_CLEAR:  state_nxt = S_CLEAR;
            CMD_CURSOR: state_nxt = S_CURSOR;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        quo_nxt  = dq;
        rem_nxt  = dr;
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          // Digit complete: store the remainder, carry on with the quotient.
          dig_we   = 1'b1;
          cnt_nxt  = cnt_inc;
          rem_nxt  = '0;
          step_nxt = '0;
          if (dq == '0 || cnt_inc == DIG_LIM) begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        char_nxt  = digit_char(rd_r);
        cnt_nxt   = cnt_dec;
        state_nxt = S_PLACE;
      end
      S_PLACE: begin
        if (char_r == CHAR_NEWLINE) begin
          col_nxt   = '0;
          row_nxt   = (wrap_row < ROW_LIM) ? wrap_row + 1'b1 : wrap_row;
          state_nxt = done_state;
        end else if (wrap_row >= ROW_LIM) begin
          // Ran off the bottom: clear and home, staying in S_PLACE to place the cell after.
          if (free) begin
            emit          = 1'b1;
            out_kind_nxt  = KIND_CLEAR;
            out_col_nxt   = '0;
            out_row_nxt   = '0;
            out_glyph_nxt = '0;
            out_attr_nxt  = '0;
            out_last_nxt  = 1'b0;
            col_nxt       = '0;
            row_nxt       = '0;
          end
        end else if (free) begin
          emit          = 1'b1;
          out_kind_nxt  = KIND_CELL;
          out_col_nxt   = wrap_col;
          out_row_nxt   = wrap_row;
          out_glyph_nxt = char_r;
          out_attr_nxt  = color_r;
          out_last_nxt  = single_r;
          col_nxt       = wrap_col + 1'b1;
          row_nxt       = wrap_row;
          state_nxt     = done_state;
        end
      end
      S_CURSOR: begin
        if (free) begin
          emit          = 1'b1;
          out_kind_nxt  = KIND_CURSOR;
          out_col_nxt   = col_r;
          out_row_nxt   = row_r;
          out_glyph_nxt = '0;
          out_attr_nxt  = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (free) begin
          emit          = 1'b1;
          out_kind_nxt  = KIND_CLEAR;
          out_col_nxt   = '0;
          out_row_nxt   = '0;
          out_glyph_nxt = '0;
          out_attr_nxt  = '0;
          out_last_nxt  = 1'b1;
          col_nxt       = '0;
          row_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      color_r     <= COLOR_RESET;
      col_r       <= '0;
      row_r       <= '0;
      quo_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      color_r     <= color_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      quo_r       <= quo_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r      <= char_nxt;
    single_r    <= single_nxt;
    base_r      <= base_nxt;
    rem_r       <= rem_nxt;
    step_r      <= step_nxt;
    cnt_r       <= cnt_nxt;
    out_kind_r  <= out_kind_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_glyph_r <= out_glyph_nxt;
    out_attr_r  <= out_attr_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Digit store: written least significant digit first, read back from the top.
  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_mem[cnt_r[DIG_AW-1:0]] <= dr;
    end
    rd_r <= dig_mem[cnt_dec[DIG_AW-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_col   = out_col_r;
  assign out_row   = out_row_r;
  assign out_glyph = out_glyph_r;
  assign out_attr  = out_attr_r;
  assign out_last  = out_last_r;

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the text console writer
// Drives put-character, put-number, clear and cursor commands through the
// valid/stall input channel and checks every console result, field by field,
// against the script for typed scripted rows, else against an in-bench model
// of the cursor and colour state. Scripted rows run first, then random command
// sequences under four handshake pressure settings, each with its own colour.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 400;
  localparam int PHASE_ITEMS   = 50;
  localparam int GAP_PCT   [4] = '{0, 69, 0, 20};
  localparam int STALL_PCT [4] = '{0, 0, 69, 20};

  typedef struct packed {
    logic [1:0] kind;
    col_t       col;
    row_t       row;
    logic [7:0] glyph;
    logic [7:0] attr;
    logic       last;
  } console_op_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        ch;
    logic [VAL_W-1:0]  value;
    logic [BASE_W-1:0] base;
    logic              typed;
    logic              has_op;
    console_op_t       op;
  } script_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [7:0]        cfg_data  = 8'h00;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [1:0]        in_cmd    = CMD_CURSOR;
  logic [7:0]        in_ch     = 8'h00;
  logic [VAL_W-1:0]  in_value  = '0;
  logic [BASE_W-1:0] in_base   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_kind;
  col_t              out_col;
  row_t              out_row;
  logic [7:0]        out_glyph;
  logic [7:0]        out_attr;
  logic              out_last;

  // Model state: cursor and the colour register.
  col_t       cur_col  = '0;
  row_t       cur_row  = '0;
  logic [7:0] attr_reg = COLOR_RESET;

  console_op_t step_ops[$];
  console_op_t due_ops[$];

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int fault_count    = 0;
  int commands_sent  = 0;
  int busy_commands  = 0;
  int results_seen   = 0;
  int clears_seen    = 0;
  int quiet_cycles   = 0;

  // Scripted opening: typed rows can be read straight off the behaviour,
  // the rest are left to the model.
  script_row_t script [23] = '{
    '{CMD_CURSOR,   8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b1,
      {KIND_CURSOR, 7'd0, 5'd0, 8'h00, 8'h00, 1'b1}},
    '{CMD_PUT_CHAR, 8'h41, 32'h0000_0000, 6'd0,  1'b1, 1'b1,
      {KIND_CELL, 7'd0, 5'd0, 8'h41, COLOR_RESET, 1'b1}},
    '{CMD_PUT_CHAR, 8'hff, 32'hffff_ffff, 6'd63, 1'b1, 1'b1,
      {KIND_CELL, 7'd1, 5'd0, 8'hff, COLOR_RESET, 1'b1}},
    '{CMD_PUT_CHAR, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b1,
      {KIND_CELL, 7'd2, 5'd0, 8'h00, COLOR_RESET, 1'b1}},
    '{CMD_PUT_NUM,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b1,
      {KIND_CELL, 7'd3, 5'd0, CHAR_ZERO, COLOR_RESET, 1'b1}},
    '{CMD_PUT_NUM,  8'hff, 32'h0000_0000, 6'd63, 1'b1, 1'b1,
      {KIND_CELL, 7'd4, 5'd0, CHAR_ZERO, COLOR_RESET, 1'b1}},
    '{CMD_PUT_NUM,  8'h00, 32'hffff_ffff, 6'd0,  1'b1, 1'b0, '0},
    '{CMD_PUT_NUM,  8'h00, 32'hffff_ffff, 6'd1,  1'b1, 1'b0, '0},
    '{CMD_PUT_NUM,  8'h00, 32'h0000_3039, 6'd37, 1'b1, 1'b0, '0},
    '{CMD_PUT_NUM,  8'h00, 32'h0000_0001, 6'd63, 1'b1, 1'b0, '0},
    '{CMD_PUT_CHAR, CHAR_NEWLINE, 32'h0, 6'd0,   1'b1, 1'b0, '0},
    '{CMD_CURSOR,   8'hff, 32'hffff_ffff, 6'd63, 1'b1, 1'b1,
      {KIND_CURSOR, 7'd0, 5'd1, 8'h00, 8'h00, 1'b1}},
    '{CMD_CLEAR,    8'hff, 32'hffff_ffff, 6'd63, 1'b1, 1'b1,
      {KIND_CLEAR, 7'd0, 5'd0, 8'h00, 8'h00, 1'b1}},
    '{CMD_PUT_NUM,  8'h00, 32'hffff_ffff, 6'd2,  1'b0, 1'b0, '0},
    '{CMD_PUT_NUM,  8'h00, 32'hffff_ffff, 6'd36, 1'b0, 1'b0, '0},
    '{CMD_PUT_NUM,  8'h00, 32'h8000_0000, 6'd16, 1'b0, 1'b0, '0},
    '{CMD_PUT_NUM,  8'h00, 32'h0000_0023, 6'd36, 1'b0, 1'b0, '0},
    '{CMD_PUT_NUM,  8'h00, 32'hffff_ffff, 6'd10, 1'b0, 1'b0, '0},
    '{CMD_PUT_NUM,  8'h00, 32'h0000_ffff, 6'd2,  1'b0, 1'b0, '0},
    // Six binary digits end exactly on the last column, so the cursor
    // report shows the column one past the edge.
    '{CMD_PUT_NUM,  8'h00, 32'h0000_003f, 6'd2,  1'b0, 1'b0, '0},
    '{CMD_PUT_CHAR, 8'h78, 32'h0000_0000, 6'd0,  1'b0, 1'b0, '0},
    '{CMD_PUT_NUM,  8'h00, 32'h0000_0001, 6'd2,  1'b0, 1'b0, '0},
    '{CMD_CURSOR,   8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0, '0}
  };

  text_console_writer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_ch     (in_ch),
    .in_value  (in_value),
    .in_base   (in_base),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_col   (out_col),
    .out_row   (out_row),
    .out_glyph (out_glyph),
    .out_attr  (out_attr),
    .out_last  (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic emit_op(input logic [1:0] kind, input col_t col, input row_t row,
                         input logic [7:0] glyph, input logic [7:0] attr);
    step_ops.push_back({kind, col, row, glyph, attr, 1'b0});
  endtask

  task automatic advance_row();
    cur_col = '0;
    if (cur_row < ROWS) begin
      cur_row = cur_row + 1'b1;
    end
  endtask

  task automatic place_glyph(input logic [7:0] c);
    if (cur_col >= COLUMNS) begin
      advance_row();
    end
    if (c == CHAR_NEWLINE) begin
      advance_row();
    end else begin
      // Running off the bottom clears the screen before the cell is written.
      if (cur_row >= ROWS) begin
        emit_op(KIND_CLEAR, '0, '0, 8'h00, 8'h00);
        cur_col = '0;
        cur_row = '0;
      end
      emit_op(KIND_CELL, cur_col, cur_row, c, attr_reg);
      cur_col = cur_col + 1'b1;
    end
  endtask

  // Works out the console results of one command and updates the cursor.
  task automatic predict_console_ops(input logic [1:0] cmd, input logic [7:0] ch,
                                     input logic [VAL_W-1:0] value,
                                     input logic [BASE_W-1:0] base);
    logic [31:0] quo;
    logic [31:0] radix;
    logic [7:0]  digs [32];
    int          n;
    step_ops.delete();
    radix = {26'd0, base};
    case (cmd)
      CMD_PUT_CHAR: begin
        place_glyph(ch);
      end
      CMD_PUT_NUM: begin
        if (value == '0) begin
          place_glyph(CHAR_ZERO);
        end else if (base >= BASE_MIN && base <= BASE_MAX) begin
          quo = value;
          n = 0;
          while (quo != 0 && n < MAX_DIGITS) begin
            digs[n] = 8'(quo % radix);
            quo = quo / radix;
            n++;
          end
          while (n > 0) begin
            n--;
            // Digits above nine are lower-case letters from 'a' (0x61).
            place_glyph(digs[n] < 8'd10 ? CHAR_ZERO + digs[n] : 8'h61 + digs[n] - 8'd10);
          end
          emit_op(KIND_CURSOR, cur_col, cur_row, 8'h00, 8'h00);
        end
      end
      CMD_CLEAR: begin
        emit_op(KIND_CLEAR, '0, '0, 8'h00, 8'h00);
        cur_col = '0;
        cur_row = '0;
      end
      default: begin
        emit_op(KIND_CURSOR, cur_col, cur_row, 8'h00, 8'h00);
      end
    endcase
    if (step_ops.size() > 0) begin
      step_ops[step_ops.size() - 1].last = 1'b1;
    end
  endtask

  // Presents one command, waits for it to be taken, then predicts its results.
  task automatic drive_command(input logic [1:0] cmd, input logic [7:0] ch,
                               input logic [VAL_W-1:0] value,
                               input logic [BASE_W-1:0] base, input bit take_model);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_ch    <= ch;
    in_value <= value;
    in_base  <= base;
    do @(posedge clk); while (in_stall);
    commands_sent++;
    predict_console_ops(cmd, ch, value, base);
    if (step_ops.size() > 0 || cmd == CMD_PUT_CHAR) begin
      busy_commands++;
    end
    if (take_model) begin
      foreach (step_ops[i]) due_ops.push_back(step_ops[i]);
    end
  endtask

  // The colour may only change once the block has gone quiet.
  task automatic set_colour_when_idle(input logic [7:0] colour);
    in_valid <= 1'b0;
    while (due_ops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= colour;
    @(posedge clk);
    cfg_we   <= 1'b0;
    attr_reg  = colour;
  endtask

  always @(posedge clk) begin
    console_op_t seen;
    console_op_t want;
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_kind, out_col, out_row, out_glyph, out_attr, out_last};
      results_seen++;
      if (out_kind == KIND_CLEAR) begin
        clears_seen++;
      end
      if (due_ops.size() == 0) begin
        fault_count++;
        $display("[%0t] unexpected result: kind=%0d col=%0d row=%0d glyph=%02h attr=%02h last=%0b",
                 $realtime, seen.kind, seen.col, seen.row, seen.glyph, seen.attr, seen.last);
      end else begin
        want = due_ops.pop_front();
        if (seen !== want) begin
          fault_count++;
          $display("[%0t] mismatch: expected kind=%0d col=%0d row=%0d glyph=%02h attr=%02h last=%0b",
                   $realtime, want.kind, want.col, want.row, want.glyph, want.attr, want.last);
          $display("[%0t]           actual kind=%0d col=%0d row=%0d glyph=%02h attr=%02h last=%0b",
                   $realtime, seen.kind, seen.col, seen.row, seen.glyph, seen.attr, seen.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[%0t] no item moved for %0d cycles, %0d results outstanding",
             $realtime, QUIET_LIMIT, due_ops.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int          pick;
    int          n;
    int          len;
    int          phase_base;
    int          scripted;
    logic [31:0] v;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      drive_command(script[i].cmd, script[i].ch, script[i].value, script[i].base,
                    !script[i].typed);
      if (script[i].typed && script[i].has_op) begin
        due_ops.push_back(script[i].op);
      end
    end
    scripted = commands_sent;

    for (int p = 0; p < 4; p++) begin
      set_colour_when_idle(p == 0 ? 8'h00 : p == 1 ? 8'hff : 8'($urandom_range(1, 254)));
      send_gap_pct   = GAP_PCT[p];
      recv_stall_pct = STALL_PCT[p];
      phase_base     = busy_commands;
      while (busy_commands - phase_base < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          // Anything at all, including bad radixes and don't-care fields.
          drive_command(2'($urandom_range(0, 3)), 8'($urandom()), $urandom(),
                        6'($urandom_range(0, 63)), 1'b1);
        end else if (pick < 55) begin
          n = $urandom_range(1, 8);
          repeat (n) begin
            drive_command(CMD_PUT_CHAR,
                          $urandom_range(0, 5) == 0 ? CHAR_NEWLINE : 8'($urandom()),
                          $urandom(), 6'($urandom()), 1'b1);
          end
        end else if (pick < 75) begin
          len = $urandom_range(0, 32);
          v   = (len == 0) ? 32'd0 : $urandom() >> (32 - len);
          drive_command(CMD_PUT_NUM, 8'($urandom()), v,
                        $urandom_range(0, 3) == 0 ? 6'd2 : 6'($urandom_range(2, 36)), 1'b1);
        end else if (pick < 88) begin
          // Fill a row exactly with binary digits, then wrap onto the next.
          drive_command(CMD_PUT_CHAR, CHAR_NEWLINE, $urandom(), 6'($urandom()), 1'b1);
          repeat (2) begin
            drive_command(CMD_PUT_NUM, 8'($urandom()), $urandom() | 32'h8000_0000,
                          6'd2, 1'b1);
          end
          drive_command(CMD_PUT_NUM, 8'($urandom()),
                        ($urandom() & 32'h0000_ffff) | 32'h0000_8000, 6'd2, 1'b1);
          drive_command(CMD_PUT_CHAR, 8'($urandom_range(32, 126)), $urandom(),
                        6'($urandom()), 1'b1);
        end else begin
          // Push the cursor down with newlines; when it runs off the bottom the row saturates and clears.
          n = $urandom_range(5, 30);
          repeat (n) begin
            drive_command(CMD_PUT_CHAR, CHAR_NEWLINE, $urandom(), 6'($urandom()), 1'b1);
          end
          if ($urandom_range(0, 1) == 1) begin
            drive_command(CMD_CURSOR, 8'($urandom()), $urandom(), 6'($urandom()), 1'b1);
          end
          n = $urandom_range(1, 3);
          repeat (n) begin
            drive_command(CMD_PUT_CHAR, 8'($urandom_range(32, 126)), $urandom(),
                          6'($urandom()), 1'b1);
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (due_ops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d commands (%0d scripted) and %0d checked results, %0d clears,",
             commands_sent, scripted, results_seen, clears_seen);
    $display("across four handshake pressure settings and five text colours.");
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
